>>> rtl/core/cle_pkg.sv
// shared types and constants for the circular list engine
package cle_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned PtrW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned SumW     = CntW + 1;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_DELETE     = 2'd2,
    CMD_READOUT    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ENTRY    = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] value;
  } cle_req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] entry;
    logic               last_result;
  } cle_res_t;

endpackage

>>> rtl/core/cle_ram.sv
// generic single write port, single read port ram with registered read
module cle_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/cle_ctrl.sv
// command sequencer: pointer state, search, compaction and readout over the ram
module cle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cle_pkg::cle_req_t in_req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output cle_pkg::cle_res_t res_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [cle_pkg::PtrW-1:0]    head_q, head_d;
  logic [cle_pkg::CntW-1:0]    count_q, count_d;
  logic [cle_pkg::DataW-1:0]   key_q, key_d;
  logic [cle_pkg::PtrW-1:0]    rd_pos_q, rd_pos_d;
  logic [cle_pkg::CntW-1:0]    rd_idx_q, rd_idx_d;
  logic [cle_pkg::PtrW-1:0]    wr_pos_q, wr_pos_d;
  cle_pkg::status_e            status_q, status_d;

  logic                        mem_we, mem_re;
  logic [cle_pkg::PtrW-1:0]    mem_waddr, mem_raddr;
  logic [cle_pkg::DataW-1:0]   mem_wdata, mem_rdata;

  logic [cle_pkg::PtrW-1:0]    prev_head, nxt_pos, tail_pos;
  logic [cle_pkg::SumW-1:0]    tail_sum;
  logic                        full, empty, idx_last;

  cle_ram #(
    .Width(cle_pkg::DataW),
    .Depth(cle_pkg::CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // ring arithmetic without modulo
  assign prev_head = (head_q == '0) ? cle_pkg::PtrW'(cle_pkg::CAPACITY - 1)
                                    : head_q - cle_pkg::PtrW'(1);
  assign nxt_pos   = (rd_pos_q == cle_pkg::PtrW'(cle_pkg::CAPACITY - 1)) ? '0
                                    : rd_pos_q + cle_pkg::PtrW'(1);
  assign tail_sum  = cle_pkg::SumW'(head_q) + cle_pkg::SumW'(count_q);
  assign tail_pos  = (tail_sum >= cle_pkg::SumW'(cle_pkg::CAPACITY))
                   ? cle_pkg::PtrW'(tail_sum - cle_pkg::SumW'(cle_pkg::CAPACITY))
                   : cle_pkg::PtrW'(tail_sum);
  assign full      = (count_q == cle_pkg::CntW'(cle_pkg::CAPACITY));
  assign empty     = (count_q == '0);
  assign idx_last  = (cle_pkg::CntW'(rd_idx_q + cle_pkg::CntW'(1)) == count_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    key_d     = key_q;
    rd_pos_d  = rd_pos_q;
    rd_idx_d  = rd_idx_q;
    wr_pos_d  = wr_pos_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_wdata = in_req_i.value;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o.status      = cle_pkg::ST_DONE;
    res_o.entry       = '0;
    res_o.last_result = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = res_ready_i;
        if (in_valid_i && res_ready_i) begin
          case (in_req_i.cmd) inside
            cle_pkg::CMD_PUSH_FRONT, cle_pkg::CMD_PUSH_BACK: begin
              res_valid_o = 1'b1;
              if (full) begin
                res_o.status = cle_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + cle_pkg::CntW'(1);
                if (in_req_i.cmd == cle_pkg::CMD_PUSH_FRONT) begin
                  head_d    = prev_head;
                  mem_waddr = prev_head;
                end else begin
                  mem_waddr = tail_pos;
                end
              end
            end
            cle_pkg::CMD_DELETE, cle_pkg::CMD_READOUT: begin
              if (empty) begin
                res_valid_o  = 1'b1;
                res_o.status = cle_pkg::ST_EMPTY;
              end else begin
                key_d     = in_req_i.value;
                mem_re    = 1'b1;
                mem_raddr = head_q;
                rd_pos_d  = head_q;
                rd_idx_d  = '0;
                state_d   = (in_req_i.cmd == cle_pkg::CMD_DELETE) ? S_SEARCH : S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_SEARCH: begin
        if (mem_rdata == key_q) begin
          if (idx_last) begin
            count_d  = count_q - cle_pkg::CntW'(1);
            status_d = cle_pkg::ST_DONE;
            state_d  = S_RESP;
          end else begin
            wr_pos_d  = rd_pos_q;
            mem_re    = 1'b1;
            mem_raddr = nxt_pos;
            rd_pos_d  = nxt_pos;
            rd_idx_d  = rd_idx_q + cle_pkg::CntW'(1);
            state_d   = S_SHIFT;
          end
        end else if (idx_last) begin
          status_d = cle_pkg::ST_NOTFOUND;
          state_d  = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = nxt_pos;
          rd_pos_d  = nxt_pos;
          rd_idx_d  = rd_idx_q + cle_pkg::CntW'(1);
        end
      end
      S_SHIFT: begin
        // move the entry just read one slot toward the head
        mem_we    = 1'b1;
        mem_waddr = wr_pos_q;
        mem_wdata = mem_rdata;
        wr_pos_d  = rd_pos_q;
        if (idx_last) begin
          count_d  = count_q - cle_pkg::CntW'(1);
          status_d = cle_pkg::ST_DONE;
          state_d  = S_RESP;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = nxt_pos;
          rd_pos_d  = nxt_pos;
          rd_idx_d  = rd_idx_q + cle_pkg::CntW'(1);
        end
      end
      S_READ: begin
        res_valid_o       = 1'b1;
        res_o.status      = cle_pkg::ST_ENTRY;
        res_o.entry       = mem_rdata;
        res_o.last_result = idx_last;
        if (res_ready_i) begin
          if (idx_last) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = nxt_pos;
            rd_pos_d  = nxt_pos;
            rd_idx_d  = rd_idx_q + cle_pkg::CntW'(1);
          end
        end
      end
      S_RESP: begin
        res_valid_o  = 1'b1;
        res_o.status = status_q;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    rd_pos_q <= rd_pos_d;
    rd_idx_q <= rd_idx_d;
    wr_pos_q <= wr_pos_d;
    status_q <= status_d;
  end

endmodule

>>> rtl/core/circular_list_engine_unit.sv
// top level of the circular list engine: sequencer plus registered result stage
// push, and delete or readout on an empty list: answered from idle, result seen the next cycle
// delete: one ram read per step, compaction runs right behind the search
// readout: one entry per cycle while the output register takes it, paced by the single ram read port
// one request in flight at a time; a new request is taken once the result register is free
// reset empties the list (head and count cleared); the entry ram is not cleared
module circular_list_engine_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cle_pkg::cle_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cle_pkg::cle_res_t out_res_o
);

  logic              res_valid;
  logic              res_ready;
  cle_pkg::cle_res_t res;

  logic              out_valid_q, out_valid_d;
  cle_pkg::cle_res_t out_res_q;

  // sequencer owns the list state and the entry ram
  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register takes a new result when empty or being drained this cycle
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only on a handoff from the sequencer
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

>>> tb/tb_circular_list_engine_unit.sv
// self-checking testbench for the circular list engine: random requests, predicted results
`timescale 1ns / 1ps

module tb_circular_list_engine_unit;
  import cle_pkg::*;

  // run limits and pacing
  localparam int unsigned TIMEOUT_CYCLES = 600_000;
  localparam int unsigned TAIL_ITEMS     = 50;   // no idling once fewer than this many requests remain
  localparam int unsigned SETTLE_CYCLES  = 64;   // quiet spell after the last result, for strays
  localparam int unsigned PHASE_ITEMS    = 52;

  typedef struct {
    cle_req_t req;
    bit       hold;  // wait until every predicted result has arrived before sending
  } planned_req_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  cle_req_t in_req_i    = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  cle_res_t out_res_o;

  planned_req_t cmd_backlog[$];   // requests not yet presented to the block
  cle_res_t     due_results[$];   // predicted results, oldest first
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;

  // predictor state: ring of entries with head and count
  logic [31:0]  ring_mem [CAPACITY];
  int unsigned  ring_head  = 0;
  int unsigned  ring_count = 0;

  // generator view of the list contents, head first, used to pick delete keys that hit
  logic [31:0]  plan_list[$];

  // idle burst bookkeeping for each side
  int unsigned  drv_gap  = 0;
  int unsigned  drv_calm = 0;
  int unsigned  rcv_stall = 0;
  int unsigned  rcv_calm  = 0;

  circular_list_engine_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("circular_list_engine_unit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned ring_slot(input int unsigned offset);
    return (ring_head + offset) % CAPACITY;
  endfunction

  function automatic cle_res_t pack_res(input status_e st, input logic [31:0] ent,
                                        input logic lst);
    cle_res_t r;
    r.status      = st;
    r.entry       = ent;
    r.last_result = lst;
    return r;
  endfunction

  // apply one accepted request to the ring and queue the results it causes
  task automatic apply_list_cmd(input cle_req_t req);
    int unsigned hit;
    int unsigned k;
    hit = ring_count;
    case (req.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (ring_count >= CAPACITY) begin
          // refused push leaves the list untouched
          due_results.push_back(pack_res(ST_FULL, '0, 1'b1));
        end else begin
          if (req.cmd == CMD_PUSH_FRONT) begin
            ring_head = (ring_head + CAPACITY - 1) % CAPACITY;
            ring_mem[ring_head] = req.value;
          end else begin
            ring_mem[ring_slot(ring_count)] = req.value;
          end
          ring_count++;
          due_results.push_back(pack_res(ST_DONE, '0, 1'b1));
        end
      end
      CMD_DELETE: begin
        if (ring_count == 0) begin
          due_results.push_back(pack_res(ST_EMPTY, '0, 1'b1));
        end else begin
          // first match searching from the head, full 32-bit compare
          for (k = 0; k < ring_count; k++) begin
            if (hit == ring_count && ring_mem[ring_slot(k)] == req.value) hit = k;
          end
          if (hit == ring_count) begin
            due_results.push_back(pack_res(ST_NOTFOUND, '0, 1'b1));
          end else begin
            // close the gap, later entries keep their order
            for (k = hit; k + 1 < ring_count; k++) begin
              ring_mem[ring_slot(k)] = ring_mem[ring_slot(k + 1)];
            end
            ring_count--;
            due_results.push_back(pack_res(ST_DONE, '0, 1'b1));
          end
        end
      end
      default: begin
        if (ring_count == 0) begin
          due_results.push_back(pack_res(ST_EMPTY, '0, 1'b1));
        end else begin
          for (k = 0; k < ring_count; k++) begin
            due_results.push_back(pack_res(ST_ENTRY, ring_mem[ring_slot(k)],
                                           (k + 1 == ring_count)));
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus planning
  // ---------------------------------------------------------------------------

  // queue one request and track what the list will hold afterwards
  task automatic plan_cmd(input cmd_e cmd, input logic [31:0] val, input bit hold);
    planned_req_t p;
    int unsigned  k;
    p.req.cmd   = cmd;
    p.req.value = val;
    p.hold      = hold;
    cmd_backlog.push_back(p);
    case (cmd)
      CMD_PUSH_FRONT: if (plan_list.size() < CAPACITY) plan_list.push_front(val);
      CMD_PUSH_BACK:  if (plan_list.size() < CAPACITY) plan_list.push_back(val);
      CMD_DELETE: begin
        for (k = 0; k < plan_list.size(); k++) begin
          if (plan_list[k] == val) begin
            plan_list.delete(k);
            break;
          end
        end
      end
      default: ;
    endcase
  endtask

  // small pool for duplicates, edge patterns, and fully random words
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'($urandom_range(0, 7));
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        default: return 32'h1 << $urandom_range(0, 31);
      endcase
    end
    return $urandom();
  endfunction

  // mostly keys that are in the list, so deletes reach the compaction path
  function automatic logic [31:0] pick_key();
    if (plan_list.size() != 0 && $urandom_range(0, 9) < 8)
      return plan_list[$urandom_range(0, plan_list.size() - 1)];
    return pick_value();
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : drive_reqs
    logic         v_n;
    cle_req_t     r_n;
    planned_req_t p_n;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      v_n = in_valid_i;
      r_n = in_req_i;
      // request taken at this edge
      if (in_valid_i && in_ready_o) begin
        apply_list_cmd(in_req_i);
        v_n = 1'b0;
      end
      if (!v_n) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (cmd_backlog.size() != 0) begin
          if (cmd_backlog[0].hold && due_results.size() != 0) begin
            // pause until the block has delivered everything owed
          end else if (cmd_backlog.size() >= TAIL_ITEMS && drv_calm == 0 &&
                       $urandom_range(0, 3) == 0) begin
            drv_gap  = $urandom_range(1, 15) - 1;
            drv_calm = $urandom_range(0, 60);
          end else begin
            if (drv_calm > 0) drv_calm--;
            p_n = cmd_backlog.pop_front();
            r_n = p_n.req;
            v_n = 1'b1;
          end
        end
      end
      in_valid_i <= v_n;
      in_req_i   <= r_n;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    cle_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d entry %0h last %0b",
                 out_res_o.status, out_res_o.entry, out_res_o.last_result);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_res_o.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_res_o.status);
            fail_count++;
          end
          if (out_res_o.entry !== want.entry) begin
            $error("entry: expected %0h, actual %0h", want.entry, out_res_o.entry);
            fail_count++;
          end
          if (out_res_o.last_result !== want.last_result) begin
            $error("last_result: expected %0b, actual %0b",
                   want.last_result, out_res_o.last_result);
            fail_count++;
          end
        end
      end
      // receiver stall bursts, none near the end of the run
      if (rcv_stall > 0) begin
        rcv_stall--;
      end else if (cmd_backlog.size() >= TAIL_ITEMS) begin
        if (rcv_calm > 0) begin
          rcv_calm--;
        end else if ($urandom_range(0, 3) == 0) begin
          rcv_stall = $urandom_range(1, 15);
          rcv_calm  = $urandom_range(0, 60);
        end
      end
      out_ready_i <= (rcv_stall == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: directed requests, random phases, reset, drain, verdict
  // ---------------------------------------------------------------------------

  initial begin : run_seq
    int unsigned phase_kind [4];
    int unsigned p;
    int unsigned n;
    int unsigned r;
    int unsigned w_front;
    int unsigned w_back;
    int unsigned w_del;
    phase_kind = '{0, 3, 1, 2};

    // directed: empty list, extremes, duplicates, delete at head, tail and middle
    plan_cmd(CMD_READOUT,    32'h0,        1'b0);
    plan_cmd(CMD_DELETE,     32'h0,        1'b0);
    plan_cmd(CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
    plan_cmd(CMD_PUSH_BACK,  32'h8000_0000, 1'b0);
    plan_cmd(CMD_PUSH_FRONT, 32'h0,        1'b0);
    plan_cmd(CMD_PUSH_BACK,  32'hffff_ffff, 1'b0);
    plan_cmd(CMD_PUSH_BACK,  32'h7fff_ffff, 1'b0);
    plan_cmd(CMD_READOUT,    32'hffff_ffff, 1'b0);
    plan_cmd(CMD_DELETE,     32'h0001_2345, 1'b0);
    plan_cmd(CMD_DELETE,     32'h7fff_ffff, 1'b0);  // first of two matches
    plan_cmd(CMD_READOUT,    32'h0,        1'b0);
    plan_cmd(CMD_DELETE,     32'hffff_ffff, 1'b0);
    plan_cmd(CMD_DELETE,     32'h8000_0000, 1'b0);
    plan_cmd(CMD_DELETE,     32'h0,        1'b0);  // head entry
    plan_cmd(CMD_READOUT,    32'h0,        1'b0);
    plan_cmd(CMD_DELETE,     32'h7fff_ffff, 1'b0);  // last entry, list empties
    plan_cmd(CMD_READOUT,    32'h5555_aaaa, 1'b0);

    // random phases: fill, overfill, churn, drain; each opens after a full drain
    for (p = 0; p < 8; p++) begin
      case (phase_kind[p % 4])
        0:       begin w_front = 40; w_back = 40; w_del = 10; end
        1:       begin w_front = 25; w_back = 25; w_del = 30; end
        2:       begin w_front = 5;  w_back = 5;  w_del = 75; end
        default: begin w_front = 45; w_back = 40; w_del = 5;  end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < w_front)
          plan_cmd(CMD_PUSH_FRONT, pick_value(), n == 0);
        else if (r < w_front + w_back)
          plan_cmd(CMD_PUSH_BACK, pick_value(), n == 0);
        else if (r < w_front + w_back + w_del)
          plan_cmd(CMD_DELETE, pick_key(), n == 0);
        else
          plan_cmd(CMD_READOUT, $urandom(), n == 0);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything sent, then everything received, then a quiet spell for strays
    while (cmd_backlog.size() != 0 || in_valid_i) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && due_results.size() == 0) begin
      $display("circular_list_engine_unit verification clean");
    end else begin
      $display("circular_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule
